[src/ecc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_pkg: elevator call controller definitions
// Shared types, codes and small arithmetic helpers for the controller.
// ----------------------------------------------------------------------------
package ecc_pkg;

    // Number of served floors (floor n sits at position 10n)
    localparam int FLOOR_COUNT = 4;

    localparam int POS_W     = 6;
    localparam int FLOOR_W   = 3;
    localparam int CMD_W     = 2;
    localparam int VAL_W     = 8;
    localparam int TIMEOUT_W = 16;
    localparam int PERIOD_W  = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd700;
    localparam logic [PERIOD_W-1:0]  PERIOD_RST  = 10'd50;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_PERIOD = 2'd1;

    // Remote command codes
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LEVEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIRE  = 2'd2;

    // Cabin modes
    typedef enum logic [2:0] {
        M_HOME       = 3'd0,
        M_IDLE       = 3'd1,
        M_RUN_CALLER = 3'd2,
        M_WAIT_ORDER = 3'd3,
        M_RUN_ORDER  = 3'd4,
        M_DONE       = 3'd5,
        M_FIRE       = 3'd6
    } mode_t;

    // Display modes
    typedef enum logic [2:0] {
        D_DOWN  = 3'd0,
        D_UP    = 3'd1,
        D_WAIT  = 3'd2,
        D_START = 3'd3,
        D_DONE  = 3'd4
    } disp_mode_t;

    // Motor directions
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    // One input word
    typedef struct packed {
        logic [POS_W-1:0]   current_position;
        logic [FLOOR_W-1:0] floor_button;
        logic [CMD_W-1:0]   command;
        logic [VAL_W-1:0]   command_value;
    } item_t;

    // One result word
    typedef struct packed {
        logic [1:0]         motor_dir;
        logic [2:0]         cabin_mode;
        logic [2:0]         display_mode;
        logic [FLOOR_W-1:0] display_floor;
        logic               call_pending;
        logic               report_valid;
        logic [POS_W-1:0]   report_position;
    } result_t;

    // Position divided by ten, for a 6-bit position
    function automatic logic [2:0] div10(input logic [POS_W-1:0] pos);
        logic [2:0] q;
        q = 3'd0;
        for (int i = 1; i <= 6; i++)
        begin
            if (pos >= POS_W'(10 * i))
                q = 3'(i);
        end
        return q;
    endfunction

    // Floor number times ten, truncated to a position
    function automatic logic [POS_W-1:0] mul10(input logic [FLOOR_W-1:0] fl);
        logic [POS_W-1:0] f;
        f = POS_W'(fl);
        return POS_W'((f << 3) + (f << 1));
    endfunction

endpackage

[src/elevator_call_controller.sv]
`timescale 1ns / 1ps
// Path: an accepted word is held in the input register, and its result is
//   loaded into the output register once that register is free or being emptied.
// Throughput: one word per cycle without stalls; single-pass next-state logic.
// Reset (rst_n, asynchronous, active low): homing mode, empty queue, display
//   start idle, timeout 700 and report period 50; no clearing pass.
// ----------------------------------------------------------------------------
// elevator_call_controller: elevator cabin call controller
// Input register, cabin logic and report timer, output register.
// ----------------------------------------------------------------------------
module elevator_call_controller
    import ecc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // current_position[5:0], floor_button[8:6], command_value[16:9], zeros
    input  logic [23:0]          s_tdata,
    // command[1:0]
    input  logic [CMD_W-1:0]     s_tuser,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // motor_dir[1:0], cabin_mode[4:2], display_mode[7:5], display_floor[10:8],
    // call_pending[11], report_valid[12], report_position[18:13], zeros
    output logic [23:0]          m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    item_t                in_reg;
    logic                 in_vld_reg;
    result_t              out_reg;
    logic                 out_vld_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [PERIOD_W-1:0]  period_reg;

    logic                 advance;
    logic                 step;
    logic                 report;
    result_t              res;

    // Pipeline moves when the output register is free or being emptied
    assign advance   = !out_vld_reg || m_tready;
    assign step      = in_vld_reg && advance;
    assign s_tready  = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RST;
            period_reg  <= PERIOD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WAIT_TIMEOUT:  timeout_reg <= cfg_data;
                CFG_REPORT_PERIOD: period_reg  <= cfg_data[PERIOD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register: capture a word, drop it once processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_tready)
            in_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg.current_position <= s_tdata[5:0];
            in_reg.floor_button     <= s_tdata[8:6];
            in_reg.command          <= s_tuser;
            in_reg.command_value    <= s_tdata[16:9];
        end
    end

    ecc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .item         (in_reg),
        .wait_timeout (timeout_reg),
        .report       (report),
        .res          (res)
    );

    ecc_report u_report (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .period (period_reg),
        .report (report)
    );

    // Output register: hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= res;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'd0,
                       out_reg.report_position,
                       out_reg.report_valid,
                       out_reg.call_pending,
                       out_reg.display_floor,
                       out_reg.display_mode,
                       out_reg.cabin_mode,
                       out_reg.motor_dir};

    // An accepted word is waiting in the input register next cycle
    a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> in_vld_reg)
        else $error("accepted word lost");

    // A processed word always reaches the output register
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_vld_reg)
        else $error("result not loaded");

    // The input side never stalls while the output register is free
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> s_tready)
        else $error("input stalled with free output");

endmodule

[src/ecc_report.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_report: position report timer
// Counts processed words and raises a report once every period.
// ----------------------------------------------------------------------------
module ecc_report
    import ecc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [PERIOD_W-1:0] period,
    output logic                report
);

    logic [PERIOD_W-1:0] count_reg;
    logic [PERIOD_W-1:0] count_next;
    logic [PERIOD_W:0]   count_inc;

    // Advance the count and wrap on a report
    always_comb
    begin
        count_inc  = {1'b0, count_reg} + 1'b1;
        report     = (count_inc >= {1'b0, period});
        count_next = report ? '0 : count_inc[PERIOD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (step)
            count_reg <= count_next;
    end

endmodule

[src/ecc_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_core: cabin mode logic
// Holds the cabin state and works out the next state and result for a word.
// ----------------------------------------------------------------------------
module ecc_core
    import ecc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  item_t                item,
    input  logic [TIMEOUT_W-1:0] wait_timeout,
    input  logic                 report,
    output result_t              res
);

    typedef struct packed {
        disp_mode_t       dmode;
        logic [2:0]       dfloor;
    } disp_t;

    mode_t                mode_reg,   mode_next;
    logic [POS_W-1:0]     target_reg, target_next;
    logic [FLOOR_W-1:0]   pend_reg,   pend_next;
    logic                 fire_reg,   fire_next;
    logic [TIMEOUT_W-1:0] wcnt_reg,   wcnt_next;
    disp_t                disp_reg,   disp_next;

    logic [POS_W-1:0]     cur;
    logic                 btn_ok;
    logic                 val_ok;
    mode_t                mode_mid;
    logic [1:0]           dir;

    // Show travel direction toward the target; keep the display when there
    function automatic disp_t show_dir(input logic [POS_W-1:0] tgt,
                                       input logic [POS_W-1:0] pos,
                                       input disp_t            d);
        disp_t r;
        r = d;
        if (tgt > pos)
            r = '{dmode: D_UP, dfloor: div10(tgt)};
        else if (tgt < pos)
            r = '{dmode: D_DOWN, dfloor: div10(tgt)};
        return r;
    endfunction

    assign cur    = item.current_position;
    assign btn_ok = (item.floor_button >= 3'd1)
                 && (item.floor_button <= FLOOR_W'(FLOOR_COUNT));
    assign val_ok = (item.command_value >= 8'd1)
                 && (item.command_value <= VAL_W'(FLOOR_COUNT));

    // Next state: remote command, then button, then the mode rule
    always_comb
    begin
        mode_next   = mode_reg;
        target_next = target_reg;
        pend_next   = pend_reg;
        fire_next   = fire_reg;
        wcnt_next   = wcnt_reg;
        disp_next   = disp_reg;
        dir         = DIR_STOP;

        // remote command
        if (item.command == CMD_LEVEL)
        begin
            if (val_ok)
            begin
                target_next = mul10(item.command_value[FLOOR_W-1:0]);
                mode_next   = M_RUN_ORDER;
            end
        end
        else if (item.command == CMD_FIRE)
        begin
            fire_next = (item.command_value != '0);
            if (fire_next)
                mode_next = M_FIRE;
            else if (mode_next == M_FIRE)
                mode_next = M_IDLE;
        end

        mode_mid = mode_next;

        // floor button
        if (btn_ok)
        begin
            unique case (mode_mid)
                M_IDLE, M_WAIT_ORDER:
                begin
                    target_next = mul10(item.floor_button);
                    if (target_next != cur)
                    begin
                        mode_next = (mode_mid == M_IDLE) ? M_RUN_CALLER : M_RUN_ORDER;
                        disp_next = show_dir(target_next, cur, disp_next);
                    end
                    else if (mode_mid == M_IDLE)
                    begin
                        mode_next = M_WAIT_ORDER;
                        wcnt_next = wait_timeout;
                        disp_next = '{dmode: D_WAIT, dfloor: div10(target_next)};
                    end
                    else
                    begin
                        mode_next = M_DONE;
                        disp_next = '{dmode: D_DONE, dfloor: div10(target_next)};
                    end
                end
                M_RUN_CALLER, M_RUN_ORDER:
                begin
                    if (pend_next == '0)
                    begin
                        pend_next = item.floor_button;
                        disp_next = show_dir(target_next, cur, disp_next);
                    end
                end
                M_DONE:
                begin
                    if (pend_next == '0)
                        pend_next = item.floor_button;
                end
                default:
                begin
                end
            endcase
        end

        // mode rule, skipped when the button changed the mode
        if (mode_next == mode_mid)
        begin
            unique case (mode_mid)
                M_HOME:
                begin
                    target_next = mul10(div10(cur));
                    if (target_next == cur)
                    begin
                        mode_next = M_IDLE;
                        disp_next = '{dmode: D_START, dfloor: div10(cur)};
                    end
                end
                M_RUN_CALLER:
                begin
                    disp_next = show_dir(target_next, cur, disp_next);
                    if (cur == target_next && !fire_next)
                    begin
                        mode_next = M_WAIT_ORDER;
                        wcnt_next = wait_timeout;
                        disp_next = '{dmode: D_WAIT, dfloor: div10(target_next)};
                    end
                end
                M_WAIT_ORDER:
                begin
                    if (wcnt_next == '0)
                    begin
                        mode_next = M_IDLE;
                        disp_next = '{dmode: D_START, dfloor: div10(cur)};
                        if (pend_next != '0)
                        begin
                            target_next = mul10(pend_next);
                            pend_next   = '0;
                        end
                    end
                    else
                        wcnt_next = wcnt_next - 1'b1;
                end
                M_RUN_ORDER:
                begin
                    if (cur == target_next && !fire_next)
                    begin
                        mode_next = M_DONE;
                        disp_next = '{dmode: D_DONE, dfloor: div10(target_next)};
                    end
                end
                M_DONE:
                begin
                    if (pend_next != '0)
                    begin
                        target_next = mul10(pend_next);
                        pend_next   = '0;
                        mode_next   = M_RUN_CALLER;
                    end
                    else
                    begin
                        mode_next = M_IDLE;
                        disp_next = '{dmode: D_START, dfloor: div10(cur)};
                    end
                end
                default:
                begin
                end
            endcase
        end

        // motor drive
        if ((mode_next == M_HOME || mode_next == M_RUN_CALLER || mode_next == M_RUN_ORDER)
            && !fire_next && target_next != cur)
            dir = (target_next > cur) ? DIR_UP : DIR_DOWN;
    end

    // Assemble the result word
    always_comb
    begin
        res.motor_dir       = dir;
        res.cabin_mode      = mode_next;
        res.display_mode    = disp_next.dmode;
        res.display_floor   = disp_next.dfloor;
        res.call_pending    = (pend_next != '0);
        res.report_valid    = report;
        res.report_position = report ? cur : '0;
    end

    // Hold the cabin state; advance once per processed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_HOME;
            target_reg <= '0;
            pend_reg   <= '0;
            fire_reg   <= 1'b0;
            wcnt_reg   <= '0;
            disp_reg   <= '{dmode: D_START, dfloor: 3'd0};
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            target_reg <= target_next;
            pend_reg   <= pend_next;
            fire_reg   <= fire_next;
            wcnt_reg   <= wcnt_next;
            disp_reg   <= disp_next;
        end
    end

    // The motor never runs while the fire flag is raised
    a_fire_stop: assert property (@(posedge clk) disable iff (!rst_n)
        fire_next |-> res.motor_dir == DIR_STOP)
        else $error("motor driven during fire");

    // A queued call is always a served floor
    a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= FLOOR_W'(FLOOR_COUNT))
        else $error("queued call out of range");

endmodule
